// ===== src/ppg_beat_detector_core_defines.svh =====
// assertion macros for the ppg beat detector
`ifndef PPG_BEAT_DETECTOR_CORE_DEFINES_SVH
`define PPG_BEAT_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication under reset
`define PBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbd assertion failed");

// next-cycle implication under reset
`define PBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbd assertion failed");

`endif

// ===== src/pbd_pkg.sv =====
// shared types, constants and coefficient table of the ppg beat detector
package pbd_pkg;

    localparam int FIR_TAPS   = 12;
    localparam int HIST_DEPTH = FIR_TAPS - 1;
    localparam int TAP_IDX_W  = 4;
    localparam int COEF_W     = 13;
    localparam int PROD_W     = 16 + COEF_W + 1;
    localparam int FIR_SUM_W  = 31;
    localparam int FIR_SHIFT  = 15;
    localparam int DC_SHIFT   = 4;
    localparam int DC_FRAC    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWING          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWING          = 2'd2;

    localparam logic [23:0] PRESENCE_THRESHOLD_RST = 24'd1000000;
    localparam logic [15:0] MIN_SWING_RST          = 16'd20;
    localparam logic [15:0] MAX_SWING_RST          = 16'd1000;

    typedef logic [23:0]        sample_t;
    typedef logic signed [15:0] ac_t;

    typedef struct packed {
        logic [23:0] presence_threshold;
        logic [15:0] min_swing;
        logic [15:0] max_swing;
    } cfg_t;

    function automatic logic [COEF_W-1:0] fir_coef(input logic [TAP_IDX_W-1:0] idx);
        logic [COEF_W-1:0] c;
        case (idx)
            4'd0:    c = 13'd172;
            4'd1:    c = 13'd321;
            4'd2:    c = 13'd579;
            4'd3:    c = 13'd927;
            4'd4:    c = 13'd1360;
            4'd5:    c = 13'd1858;
            4'd6:    c = 13'd2390;
            4'd7:    c = 13'd2916;
            4'd8:    c = 13'd3391;
            4'd9:    c = 13'd3768;
            4'd10:   c = 13'd4012;
            4'd11:   c = 13'd4096;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== src/pbd_ifs.sv =====
// valid/ready channel interfaces of the ppg beat detector
interface pbd_sample_if;
    logic              valid;
    logic              ready;
    pbd_pkg::sample_t  ir_sample;

    modport source (output valid, output ir_sample, input ready);
    modport sink   (input valid, input ir_sample, output ready);
endinterface

interface pbd_result_if;
    logic          valid;
    logic          ready;
    logic          beat;
    logic          finger_present;
    pbd_pkg::ac_t  ac_value;

    modport source (output valid, output beat, output finger_present, output ac_value,
                    input ready);
    modport sink   (input valid, input beat, input finger_present, input ac_value,
                    output ready);
endinterface

interface pbd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pbd_pkg::CFG_IDX_W-1:0]       index;
    logic [pbd_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/pbd_fir.sv =====
// sample history and 12-tap low-pass fir
module pbd_fir (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic signed [15:0]  sample,
    output logic signed [15:0]  filt
);

    logic signed [15:0]                   hist_reg [pbd_pkg::HIST_DEPTH];
    logic signed [15:0]                   window   [pbd_pkg::FIR_TAPS];
    logic signed [pbd_pkg::PROD_W-1:0]    prod     [pbd_pkg::FIR_TAPS];
    logic signed [pbd_pkg::FIR_SUM_W-1:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pbd_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            hist_reg[0] <= sample;
            for (int i = 1; i < pbd_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // window holds the new sample at tap 0
    always_comb
    begin
        window[0] = sample;
        for (int i = 1; i < pbd_pkg::FIR_TAPS; i++)
        begin
            window[i] = hist_reg[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < pbd_pkg::FIR_TAPS; i++)
        begin
            prod[i] = window[i] *
                      $signed({1'b0, pbd_pkg::fir_coef(pbd_pkg::TAP_IDX_W'(i))});
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < pbd_pkg::FIR_TAPS; i++)
        begin
            sum = sum + {{(pbd_pkg::FIR_SUM_W-pbd_pkg::PROD_W){prod[i][pbd_pkg::PROD_W-1]}},
                         prod[i]};
        end
    end

    // arithmetic shift then wrap to 16 bits
    assign filt = sum[pbd_pkg::FIR_SHIFT+15:pbd_pkg::FIR_SHIFT];

endmodule

// ===== src/pbd_detect.sv =====
// dc removal, peak and trough tracking and beat decision
`include "ppg_beat_detector_core_defines.svh"

module pbd_detect (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic signed [15:0]  filt,
    input  pbd_pkg::cfg_t       limits,
    output logic                beat,
    output pbd_pkg::ac_t        ac_value
);

    logic [31:0]         dc_acc_reg;
    logic [31:0]         dc_acc_next;
    logic signed [33:0]  dc_diff;
    logic signed [33:0]  dc_step;
    logic signed [15:0]  dc_est;
    logic signed [15:0]  cur;
    logic signed [15:0]  prev_reg;
    logic signed [15:0]  peak_reg;
    logic signed [15:0]  peak_next;
    logic signed [15:0]  peak_base;
    logic signed [15:0]  trough_reg;
    logic signed [15:0]  trough_next;
    logic signed [15:0]  trough_base;
    logic                rising_reg;
    logic                rising_next;
    logic                falling_reg;
    logic                falling_next;
    logic                rise;
    logic                fall;
    logic signed [16:0]  swing;

    // filter output taken as unsigned for the baseline average
    assign dc_diff     = $signed({3'b000, filt, 15'b0}) - $signed({{2{dc_acc_reg[31]}}, dc_acc_reg});
    assign dc_step     = dc_diff >>> pbd_pkg::DC_SHIFT;
    assign dc_acc_next = dc_acc_reg + dc_step[31:0];
    assign dc_est      = dc_acc_next[pbd_pkg::DC_FRAC+15:pbd_pkg::DC_FRAC];
    assign cur         = filt - dc_est;

    assign rise = prev_reg[15] && !cur[15];
    assign fall = !prev_reg[15] && (prev_reg != '0) && (cur[15] || (cur == '0));

    assign swing = {peak_reg[15], peak_reg} - {trough_reg[15], trough_reg};
    assign beat  = rise &&
                   ($signed({swing[16], swing}) > $signed({2'b00, limits.min_swing})) &&
                   ($signed({swing[16], swing}) < $signed({2'b00, limits.max_swing}));

    always_comb
    begin
        rising_next  = rise ? 1'b1 : (fall ? 1'b0 : rising_reg);
        falling_next = fall ? 1'b1 : (rise ? 1'b0 : falling_reg);
        peak_base    = rise ? '0 : peak_reg;
        trough_base  = fall ? '0 : trough_reg;
        peak_next    = (rising_next && (cur > peak_base)) ? cur : peak_base;
        trough_next  = (falling_next && (cur < trough_base)) ? cur : trough_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_acc_reg  <= '0;
            prev_reg    <= '0;
            peak_reg    <= '0;
            trough_reg  <= '0;
            rising_reg  <= 1'b0;
            falling_reg <= 1'b0;
        end
        else if (en)
        begin
            dc_acc_reg  <= dc_acc_next;
            prev_reg    <= cur;
            peak_reg    <= peak_next;
            trough_reg  <= trough_next;
            rising_reg  <= rising_next;
            falling_reg <= falling_next;
        end
    end

    assign ac_value = cur;

    `PBD_ASSERT_IMPL(a_phase_excl, clk, rst_n, 1'b1, !(rising_reg && falling_reg))
    `PBD_ASSERT_IMPL(a_peak_nonneg, clk, rst_n, 1'b1, !peak_reg[15])
    `PBD_ASSERT_IMPL(a_trough_nonpos, clk, rst_n, 1'b1, trough_reg[15] || (trough_reg == '0))
    `PBD_ASSERT_IMPL(a_beat_limits, clk, rst_n, en && beat, limits.min_swing < limits.max_swing)

endmodule

// ===== src/ppg_beat_detector_core.sv =====
// top level of the ppg beat detector: config registers, stage and result registers
// usage
//   samples: one raw 24-bit infrared sample per transaction (valid/ready)
//   results: one transaction per sample with beat, finger_present and ac_value
//   cfg: register writes, index 0 presence threshold, 1 min swing, 2 max swing;
//     always ready, writes to other indexes are dropped
// timing
//   a taken sample lands in the stage register; its result moves to the result
//   register once that is free and is then valid
//   one sample per cycle while results.ready holds: the fir, dc average and
//   swing compare run in one pass from the stage register to the result register
//   a sample below the presence threshold gives an all-zero result and leaves
//   the filter and tracking state untouched
// reset
//   clears the sample history, dc average and peak tracking at once and loads
//   the register defaults; no clearing pass, samples accepted right after
// stall
//   a held result keeps its value; one more sample waits in the stage register,
//   then samples.ready drops until results.ready returns
`include "ppg_beat_detector_core_defines.svh"

module ppg_beat_detector_core (
    input  logic                 clk,
    input  logic                 rst_n,
    pbd_sample_if.sink           samples,
    pbd_result_if.source         results,
    pbd_cfg_if.sink              cfg
);

    pbd_pkg::cfg_t      cfg_reg;
    logic               s1_valid_reg;
    pbd_pkg::sample_t   s1_sample_reg;
    logic               out_valid_reg;
    logic               out_beat_reg;
    logic               out_present_reg;
    pbd_pkg::ac_t       out_ac_reg;
    logic               out_free;
    logic               advance;
    logic               present;
    logic               commit;
    logic signed [15:0] filt;
    logic               det_beat;
    pbd_pkg::ac_t       det_ac;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.presence_threshold <= pbd_pkg::PRESENCE_THRESHOLD_RST;
            cfg_reg.min_swing          <= pbd_pkg::MIN_SWING_RST;
            cfg_reg.max_swing          <= pbd_pkg::MAX_SWING_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                pbd_pkg::CFG_PRESENCE_THRESHOLD: cfg_reg.presence_threshold <= cfg.data;
                pbd_pkg::CFG_MIN_SWING:          cfg_reg.min_swing <= cfg.data[15:0];
                pbd_pkg::CFG_MAX_SWING:          cfg_reg.max_swing <= cfg.data[15:0];
                default:                         ;
            endcase
        end
    end

    assign out_free      = !out_valid_reg || results.ready;
    assign advance       = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || out_free;
    assign present       = s1_sample_reg >= cfg_reg.presence_threshold;
    assign commit        = advance && present;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (samples.ready)
            begin
                s1_valid_reg <= samples.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_sample_reg <= samples.ir_sample;
        end
        if (advance)
        begin
            out_beat_reg    <= present && det_beat;
            out_present_reg <= present;
            out_ac_reg      <= present ? det_ac : '0;
        end
    end

    pbd_fir u_fir (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (commit),
        .sample (s1_sample_reg[15:0]),
        .filt   (filt)
    );

    pbd_detect u_detect (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (commit),
        .filt     (filt),
        .limits   (cfg_reg),
        .beat     (det_beat),
        .ac_value (det_ac)
    );

    assign results.valid          = out_valid_reg;
    assign results.beat           = out_beat_reg;
    assign results.finger_present = out_present_reg;
    assign results.ac_value       = out_ac_reg;

    `PBD_ASSERT_IMPL(a_beat_present, clk, rst_n, out_valid_reg && out_beat_reg, out_present_reg)
    `PBD_ASSERT_IMPL(a_absent_zero, clk, rst_n, out_valid_reg && !out_present_reg,
                     (out_ac_reg == '0) && !out_beat_reg)
    `PBD_ASSERT_NEXT(a_stage_held, clk, rst_n, s1_valid_reg && !out_free,
                     s1_valid_reg && $stable(s1_sample_reg))

endmodule
